/* rtl/rgi_pkg.sv */
// Shared types, constants and helper functions for the rectilinear grid interpolator.
`timescale 1ns / 1ps
package rgi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GRID_MAX  = 16;
  localparam int MAX_DIMS  = 3;
  localparam int GRID_AW   = 6;
  localparam int GRID_DEPTH = MAX_DIMS * GRID_MAX;
  localparam int VAL_DEPTH = 4096;
  localparam int VAL_AW    = 12;
  localparam int DIV_LEN   = 33 + FRAC_BITS;

  localparam logic [1:0] CMD_GRID  = 2'd0;
  localparam logic [1:0] CMD_VALUE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_DIMS = 3'd1;
  localparam logic [2:0] REG_AX0  = 3'd2;
  localparam logic [2:0] REG_AX1  = 3'd3;
  localparam logic [2:0] REG_AX2  = 3'd4;

  localparam logic signed [24:0] ONE_Q  = 25'sd65536;
  localparam logic signed [23:0] HALF_Q = 24'sd32768;
  localparam logic [48:0] T_LIM = 49'd8388608;
  localparam logic signed [65:0] W_LIM    = 66'sd140737488355328;
  localparam logic signed [65:0] TERM_LIM = 66'sd288230376151711744;
  localparam logic signed [63:0] RES_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] RES_MIN  = -64'sd2147483648;

  typedef enum logic [4:0] {
    S_IDLE, S_SINIT, S_SRD, S_SCMP, S_LORD, S_HIRD, S_HICAP, S_DINIT, S_DSTEP,
    S_TSTORE, S_NRD, S_NCAP, S_CINIT, S_WLO, S_WHI, S_WEND, S_VRD, S_VCAP,
    S_VLO, S_VHI, S_VEND, S_VADD, S_DONE
  } rgi_state_t;

  typedef struct packed {
    rgi_state_t op;
    logic       take;
    logic [1:0] d;
    logic [1:0] k;
    logic [2:0] corner;
  } rgi_cmd_t;

  typedef struct packed {
    logic       srch_done;
    logic       out_free;
    logic       mode;
    logic [1:0] nd;
  } rgi_sts_t;

  // grid points per axis, held to [2, GRID_MAX]
  function automatic logic [4:0] clamp_size(input logic [4:0] s);
    logic [4:0] r;
    r = s;
    if (s < 5'd2) r = 5'd2;
    if (s > 5'(GRID_MAX)) r = 5'(GRID_MAX);
    return r;
  endfunction

  // C-order flat index, axis 0 slowest
  function automatic logic [VAL_AW-1:0] flat_index(
    input logic [3:0] c0, input logic [3:0] c1, input logic [3:0] c2,
    input logic [4:0] n1, input logic [4:0] n2, input logic [1:0] nd);
    logic [8:0]  f1;
    logic [13:0] f2;
    f1 = 9'(c0 * n1) + 9'(c1);
    f2 = 14'(f1 * n2) + 14'(c2);
    case (nd)
      2'd2:    return VAL_AW'(f1);
      2'd3:    return VAL_AW'(f2);
      default: return VAL_AW'(c0);
    endcase
  endfunction

endpackage

/* rtl/rgi_ifs.sv */
// Request and response channel interfaces of the interpolator.
`timescale 1ns / 1ps
interface rgi_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [1:0]         axis;
  logic [11:0]        position;
  logic signed [31:0] load_data;
  logic signed [31:0] coord0;
  logic signed [31:0] coord1;
  logic signed [31:0] coord2;
  modport source (output valid, command, axis, position, load_data, coord0, coord1, coord2,
                  input ready);
  modport sink (input valid, command, axis, position, load_data, coord0, coord1, coord2,
                output ready);
endinterface

interface rgi_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interp_value;
  logic               fault;
  modport source (output valid, interp_value, fault, input ready);
  modport sink (input valid, interp_value, fault, output ready);
endinterface

/* rtl/rectilinear_grid_interpolator.sv */
// Top level of the rectilinear grid interpolator.
`timescale 1ns / 1ps
// Multilinear or nearest-point interpolation on a rectilinear grid of up to
// three axes, signed Q16.16 throughout. Words with command 0 load a grid
// coordinate (axis, index), command 1 loads a value table entry (flat C-order
// index, axis 0 slowest), command 2 queries a point and returns one word;
// command 3 is dropped. A query runs one word at a time through the
// sequencer: per axis an upper-bound binary search over the grid RAM (at most
// five probes), two reads of the interval ends and a restoring divide for t;
// nearest mode then reads the table entry, linear mode weights each of the
// 2^dims corners, each 49 x 33 multiply done as two 25 x 33 partial products
// on successive cycles. The result register is then loaded. The result sits
// in an output register, so the next word is taken while a result waits.
// Grid and value tables are undefined until written; a zero-width interval
// gives t = 0 and sets fault. Configuration must be written only while idle;
// the block itself does not enforce this.
module rectilinear_grid_interpolator import rgi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [4:0] cfg_wdata,
  rgi_req_if.sink    req,
  rgi_rsp_if.source  rsp
);
  rgi_cmd_t cmd;
  rgi_sts_t sts;

  // sequencer
  rgi_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_command(req.command), .in_ready(req.ready),
    .sts(sts), .cmd(cmd));

  // datapath, tables and result register
  rgi_dp u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .command(req.command), .axis(req.axis), .position(req.position),
    .load_data(req.load_data),
    .coord0(req.coord0), .coord1(req.coord1), .coord2(req.coord2),
    .cmd(cmd), .sts(sts),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .out_value(rsp.interp_value), .out_fault(rsp.fault));
endmodule

/* rtl/rgi_ram.sv */
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module rgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/rgi_ctrl.sv */
// Sequencer for search, division, weighting and accumulation.
`timescale 1ns / 1ps
module rgi_ctrl import rgi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  input  rgi_sts_t   sts,
  output rgi_cmd_t   cmd
);
  rgi_state_t state, state_next;
  logic [1:0] d, d_next, k, k_next;
  logic [2:0] corner, corner_next, corner_last;
  logic [5:0] divcnt, divcnt_next;
  logic [1:0] nd_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      d <= '0; k <= '0; corner <= '0; divcnt <= '0;
    end else begin
      state <= state_next;
      d <= d_next; k <= k_next; corner <= corner_next; divcnt <= divcnt_next;
    end
  end

  assign nd_last = 2'(sts.nd - 2'd1);
  assign corner_last = (sts.nd == 2'd1) ? 3'd1 : (sts.nd == 2'd2) ? 3'd3 : 3'd7;

  always_comb begin
    state_next = state;
    d_next = d; k_next = k; corner_next = corner; divcnt_next = divcnt;
    in_ready = (state == S_IDLE);
    cmd.op = state;
    cmd.take = in_ready && in_valid;
    cmd.d = d; cmd.k = k; cmd.corner = corner;
    case (state)
      S_IDLE: if (in_valid && in_command == CMD_QUERY) begin
        state_next = S_SINIT; d_next = '0;
      end
      S_SINIT: state_next = S_SRD;
      S_SRD:   state_next = sts.srch_done ? S_LORD : S_SCMP;
      S_SCMP:  state_next = S_SRD;
      S_LORD:  state_next = S_HIRD;
      S_HIRD:  state_next = S_HICAP;
      S_HICAP: state_next = S_DINIT;
      S_DINIT: begin state_next = S_DSTEP; divcnt_next = '0; end
      S_DSTEP: begin
        divcnt_next = 6'(divcnt + 6'd1);
        if (divcnt == 6'(DIV_LEN - 1)) state_next = S_TSTORE;
      end
      S_TSTORE: if (d == nd_last) begin
        state_next = sts.mode ? S_NRD : S_CINIT; corner_next = '0;
      end else begin
        d_next = 2'(d + 2'd1); state_next = S_SINIT;
      end
      S_NRD:   state_next = S_NCAP;
      S_NCAP:  state_next = S_DONE;
      S_CINIT: begin state_next = S_WLO; k_next = '0; end
      S_WLO:   state_next = S_WHI;
      S_WHI:   state_next = S_WEND;
      S_WEND:  if (k == nd_last) state_next = S_VRD;
               else begin k_next = 2'(k + 2'd1); state_next = S_WLO; end
      S_VRD:   state_next = S_VCAP;
      S_VCAP:  state_next = S_VLO;
      S_VLO:   state_next = S_VHI;
      S_VHI:   state_next = S_VEND;
      S_VEND:  state_next = S_VADD;
      S_VADD:  if (corner == corner_last) state_next = S_DONE;
               else begin corner_next = 3'(corner + 3'd1); state_next = S_CINIT; end
      S_DONE:  if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/rgi_dp.sv */
// Datapath: registers, tables, divider, multiplier and result register.
`timescale 1ns / 1ps
module rgi_dp import rgi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [4:0]         cfg_wdata,
  input  logic [1:0]         command,
  input  logic [1:0]         axis,
  input  logic [11:0]        position,
  input  logic signed [31:0] load_data,
  input  logic signed [31:0] coord0,
  input  logic signed [31:0] coord1,
  input  logic signed [31:0] coord2,
  input  rgi_cmd_t           cmd,
  output rgi_sts_t           sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_fault
);
  // configuration
  logic       mode;
  logic [1:0] dims;
  logic [4:0] size [3];
  logic [4:0] n [3];
  logic [1:0] nd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0; dims <= 2'd1;
      size[0] <= 5'd2; size[1] <= 5'd2; size[2] <= 5'd2;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE: mode <= cfg_wdata[0];
        REG_DIMS: dims <= cfg_wdata[1:0];
        REG_AX0:  size[0] <= cfg_wdata;
        REG_AX1:  size[1] <= cfg_wdata;
        REG_AX2:  size[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign n[0] = clamp_size(size[0]);
  assign n[1] = clamp_size(size[1]);
  assign n[2] = clamp_size(size[2]);
  assign nd = (dims == 2'd0) ? 2'd1 : dims;

  // tables
  logic               g_we, v_we;
  logic [GRID_AW-1:0] g_raddr;
  logic [VAL_AW-1:0]  v_raddr;
  logic [31:0]        g_rdata, v_rdata;

  assign g_we = cmd.take && command == CMD_GRID && axis < 2'(MAX_DIMS)
                && position < 12'(GRID_MAX);
  assign v_we = cmd.take && command == CMD_VALUE;

  rgi_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_grid (
    .clk(clk), .we(g_we), .waddr({axis, position[3:0]}), .wdata(load_data),
    .raddr(g_raddr), .rdata(g_rdata));

  rgi_ram #(.WIDTH(32), .DEPTH(VAL_DEPTH)) u_vals (
    .clk(clk), .we(v_we), .waddr(position), .wdata(load_data),
    .raddr(v_raddr), .rdata(v_rdata));

  // query registers
  logic signed [31:0] x [3];
  logic [3:0]         idx [3];
  logic signed [23:0] t [3];
  logic [4:0]         first, count, step, it, nd_cur;
  logic [3:0]         i_sel;
  logic signed [31:0] glo, ghi;
  logic               fault, zflag, neg;
  logic [48:0]        dq;
  logic [32:0]        rem, dvs;
  logic signed [48:0] w;
  logic signed [57:0] plo, phi;
  logic signed [59:0] term;
  logic signed [63:0] acc;
  logic signed [31:0] vreg;

  assign nd_cur = n[cmd.d];
  assign step = count >> 1;
  assign it = 5'(first + step);

  always_comb begin
    logic [4:0] fm1;
    fm1 = (first == 5'd0) ? 5'd0 : 5'(first - 5'd1);
    if (fm1 > 5'(nd_cur - 5'd2)) fm1 = 5'(nd_cur - 5'd2);
    i_sel = fm1[3:0];
  end

  always_comb begin
    case (cmd.op)
      S_LORD:  g_raddr = {cmd.d, i_sel};
      S_HIRD:  g_raddr = {cmd.d, 4'(idx[cmd.d] + 4'd1)};
      default: g_raddr = {cmd.d, it[3:0]};
    endcase
  end

  // corner selection and flat address
  logic [2:0] cbit;
  always_comb begin
    if (cmd.op == S_NRD) begin
      cbit[0] = t[0] > HALF_Q; cbit[1] = t[1] > HALF_Q; cbit[2] = t[2] > HALF_Q;
    end else begin
      cbit = cmd.corner;
    end
  end
  assign v_raddr = flat_index(4'(idx[0] + 4'(cbit[0])), 4'(idx[1] + 4'(cbit[1])),
                              4'(idx[2] + 4'(cbit[2])), n[1], n[2], nd);

  // divider step and quotient saturation
  logic signed [32:0] num, den;
  logic [33:0]        rem2;
  logic               ge;
  logic signed [23:0] q_sat;
  assign num  = 33'(x[cmd.d]) - 33'(glo);
  assign den  = 33'(ghi) - 33'(glo);
  assign rem2 = {rem, dq[48]};
  assign ge   = rem2 >= {1'b0, dvs};

  always_comb begin
    if (!neg) q_sat = (dq >= T_LIM) ? 24'sh7FFFFF : $signed(dq[23:0]);
    else      q_sat = (dq > T_LIM) ? 24'sh800000 : $signed(24'(-dq));
  end

  // shared multiplier: w times weight factor or table value
  logic signed [23:0] tk;
  logic signed [24:0] fac;
  logic signed [32:0] mb;
  logic signed [81:0] full;
  logic signed [65:0] res;
  assign tk  = t[cmd.k];
  assign fac = cmd.corner[cmd.k] ? 25'(tk) : 25'(ONE_Q - 25'(tk));
  assign mb  = (cmd.op == S_VLO || cmd.op == S_VHI) ? 33'(vreg) : 33'(fac);
  assign full = (82'(phi) <<< 24) + 82'(plo);
  assign res  = full[81:16];

  always_ff @(posedge clk) begin
    case (cmd.op)
      S_IDLE: if (cmd.take) begin
        x[0] <= coord0; x[1] <= coord1; x[2] <= coord2;
        fault <= 1'b0; acc <= '0;
      end
      S_SINIT: begin first <= '0; count <= nd_cur; end
      S_SCMP: if (!(x[cmd.d] < $signed(g_rdata))) begin
        first <= 5'(it + 5'd1); count <= 5'(count - step - 5'd1);
      end else begin
        count <= step;
      end
      S_LORD:  idx[cmd.d] <= i_sel;
      S_HIRD:  glo <= $signed(g_rdata);
      S_HICAP: ghi <= $signed(g_rdata);
      S_DINIT: begin
        neg   <= num[32] ^ den[32];
        zflag <= (den == '0);
        if (den == '0) fault <= 1'b1;
        dq  <= {(num[32] ? 33'(-num) : 33'(num)), 16'd0};
        dvs <= den[32] ? 33'(-den) : 33'(den);
        rem <= '0;
      end
      S_DSTEP: begin
        rem <= ge ? 33'(rem2 - {1'b0, dvs}) : rem2[32:0];
        dq  <= {dq[47:0], ge};
      end
      S_TSTORE: t[cmd.d] <= zflag ? 24'sd0 : q_sat;
      S_NCAP:   vreg <= $signed(v_rdata);
      S_CINIT:  w <= 49'(ONE_Q);
      S_WLO, S_VLO: plo <= $signed({1'b0, w[23:0]}) * mb;
      S_WHI, S_VHI: phi <= $signed(w[48:24]) * mb;
      S_WEND: begin
        if (res > W_LIM) w <= 49'(W_LIM);
        else if (res < -W_LIM) w <= 49'(-W_LIM);
        else w <= 49'(res);
      end
      S_VCAP: vreg <= $signed(v_rdata);
      S_VEND: begin
        if (res > TERM_LIM) term <= 60'(TERM_LIM);
        else if (res < -TERM_LIM) term <= 60'(-TERM_LIM);
        else term <= 60'(res);
      end
      S_VADD: acc <= acc + 64'(term);
      default: ;
    endcase
  end

  // result register
  logic signed [31:0] lin_res;
  assign lin_res = (acc > RES_MAX) ? 32'sh7FFFFFFF :
                   (acc < RES_MIN) ? 32'sh80000000 : 32'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == S_DONE && sts.out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == S_DONE && sts.out_free) begin
      out_value <= mode ? vreg : lin_res;
      out_fault <= fault;
    end
  end

  assign sts.srch_done = (count == 5'd0);
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.mode      = mode;
  assign sts.nd        = nd;
endmodule
